// ----- rtl/dre_pkg.sv -----
// ----------------------------------------------------------------------------
// dre_pkg
// Shared types, codes and reset values of the distance repetition detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dre_pkg;

	localparam int DISTANCE_WIDTH_DEF = 13;

	// Configuration register widths
	localparam int MIN_MOVE_W   = 13;
	localparam int TIMEOUT_W    = 8;
	localparam int STREAK_W     = 4;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 13;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MOVEMENT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STREAK_LIMIT = 2'd2;

	// Configuration reset values
	localparam logic [MIN_MOVE_W-1:0] MIN_MOVE_RST = 13'd320;
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 8'd10;
	localparam logic [STREAK_W-1:0]   STREAK_RST   = 4'd6;

	localparam logic [TIMEOUT_W-1:0]  ELAPSED_MAX  = 8'd255;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_ABORTED  = 2'd2
	} status_t;

	// Movement phase
	typedef enum logic [1:0] {
		PH_SEED = 2'd0,
		PH_UP   = 2'd1,
		PH_DOWN = 2'd2
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/distance_rep_detector_unit.sv -----
// ----------------------------------------------------------------------------
// distance_rep_detector_unit
// Finds one up-and-down movement cycle in a stream of distance samples.
// ----------------------------------------------------------------------------
// The unit takes one request per clock: a distance sample, a sensor timeout
// sample or a one-second tick. Each request yields exactly one result, which
// is presented on the result port once it has moved from the input register,
// loaded at the accepting edge, into the result register. While results are
// taken a new request may follow in every cycle; the rate is set by the single
// compare-and-update pass on the peak, floor, streak and elapsed registers.
// A stalled result holds the pipe, and ready drops only when both stages are
// full and the result is not taken. The first sample seeds peak and floor,
// the up phase waits for streak_limit+1 samples well below the peak, the down
// phase waits for streak_limit+1 samples near the floor and then reports peak
// minus floor. Ticks abort a running cycle after cycle_timeout_seconds.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// issued only while the unit is idle.
`default_nettype none

module distance_rep_detector_unit
	import dre_pkg::*;
#(
	parameter int DISTANCE_WIDTH = DISTANCE_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                operation,
	input  wire logic [DISTANCE_WIDTH-1:0] distance,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic [DISTANCE_WIDTH-1:0]      movement,
	output logic [1:0]                     phase
);

	// compare width covers both the distance and the threshold
	localparam int CW = (DISTANCE_WIDTH > MIN_MOVE_W) ? DISTANCE_WIDTH : MIN_MOVE_W;

	// configuration registers
	logic [MIN_MOVE_W-1:0] min_move_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [STREAK_W-1:0]   streak_lim_q;

	// detector state
	phase_t                    phase_q;
	logic [DISTANCE_WIDTH-1:0] peak_q;
	logic [DISTANCE_WIDTH-1:0] floor_q;
	logic [STREAK_W-1:0]       streak_q;
	logic [TIMEOUT_W-1:0]      elapsed_q;

	// input stage
	logic                      valid_s1;
	logic [1:0]                op_s1;
	logic [DISTANCE_WIDTH-1:0] dist_s1;

	// result stage
	logic                      valid_s2;
	status_t                   status_s2;
	logic [DISTANCE_WIDTH-1:0] movement_s2;
	phase_t                    phase_s2;

	logic advance_s2;
	logic load_s1;

	// next state of the single pass
	phase_t                    phase_d;
	logic [DISTANCE_WIDTH-1:0] peak_d;
	logic [DISTANCE_WIDTH-1:0] floor_d;
	logic [STREAK_W-1:0]       streak_d;
	logic [TIMEOUT_W-1:0]      elapsed_d;
	status_t                   status_d;
	logic [DISTANCE_WIDTH-1:0] movement_d;

	logic [DISTANCE_WIDTH-1:0] peak_upd;
	logic [DISTANCE_WIDTH-1:0] floor_upd;
	logic [CW-1:0]             up_gap;
	logic [CW-1:0]             down_gap;
	logic [CW-1:0]             min_move_ext;
	logic                      qualifies;
	logic                      streak_done;
	logic [TIMEOUT_W-1:0]      elapsed_inc;

	// ---- handshakes --------------------------------------------------------
	assign cfg_ready  = 1'b1;
	assign advance_s2 = !valid_s2 || out_ready;
	assign in_ready   = !valid_s1 || advance_s2;
	assign load_s1    = in_valid && in_ready;

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign movement  = movement_s2;
	assign phase     = phase_s2;

	// ---- configuration -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_move_q   <= MIN_MOVE_RST;
			timeout_q    <= TIMEOUT_RST;
			streak_lim_q <= STREAK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_MOVEMENT:  min_move_q   <= cfg_data[MIN_MOVE_W-1:0];
				CFG_CYCLE_TIMEOUT: timeout_q    <= cfg_data[TIMEOUT_W-1:0];
				CFG_STREAK_LIMIT:  streak_lim_q <= cfg_data[STREAK_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// ---- input stage -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1   <= operation;
			dist_s1 <= distance;
		end
	end

	// ---- compare and update ------------------------------------------------
	// Peak and floor follow the sample first; the gaps are judged against
	// the updated values, so neither gap can go negative.
	assign peak_upd     = (dist_s1 > peak_q) ? dist_s1 : peak_q;
	assign floor_upd    = (dist_s1 < floor_q) ? dist_s1 : floor_q;
	assign up_gap       = CW'(peak_upd - dist_s1);
	assign down_gap     = CW'(dist_s1 - floor_upd);
	assign min_move_ext = CW'(min_move_q);
	assign elapsed_inc  = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		qualifies = 1'b0;
		case (phase_q)
			PH_UP:   qualifies = up_gap > min_move_ext;
			default: qualifies = down_gap < min_move_ext;
		endcase
		streak_done = qualifies && (streak_q >= streak_lim_q);
	end

	always_comb begin
		phase_d    = phase_q;
		peak_d     = peak_q;
		floor_d    = floor_q;
		streak_d   = streak_q;
		elapsed_d  = elapsed_q;
		status_d   = ST_NONE;
		movement_d = '0;
		case (op_s1)
			OP_TICK: begin
				if (phase_q != PH_SEED) begin
					if (elapsed_inc >= timeout_q) begin
						// abort: back to seeding
						status_d  = ST_ABORTED;
						phase_d   = PH_SEED;
						streak_d  = '0;
						elapsed_d = '0;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
			end
			OP_SAMPLE: begin
				case (phase_q)
					PH_SEED: begin
						// seed only, no judgement
						peak_d    = dist_s1;
						floor_d   = dist_s1;
						streak_d  = '0;
						elapsed_d = '0;
						phase_d   = PH_UP;
					end
					PH_UP: begin
						peak_d  = peak_upd;
						floor_d = floor_upd;
						if (!qualifies || streak_done) begin
							streak_d = '0;
						end else begin
							streak_d = streak_q + 1'b1;
						end
						if (streak_done) begin
							phase_d = PH_DOWN;
						end
					end
					default: begin
						floor_d = floor_upd;
						if (streak_done) begin
							// cycle complete: report and restart
							status_d   = ST_COMPLETE;
							movement_d = peak_q - floor_upd;
							phase_d    = PH_SEED;
							streak_d   = '0;
							elapsed_d  = '0;
						end else if (!qualifies) begin
							streak_d = '0;
						end else begin
							streak_d = streak_q + 1'b1;
						end
					end
				endcase
			end
			default: ;  // sensor timeout samples and unused codes: hold state
		endcase
	end

	// ---- state and result stage --------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEED;
			peak_q    <= '0;
			floor_q   <= '0;
			streak_q  <= '0;
			elapsed_q <= '0;
			valid_s2  <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q   <= phase_d;
				peak_q    <= peak_d;
				floor_q   <= floor_d;
				streak_q  <= streak_d;
				elapsed_q <= elapsed_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			status_s2   <= status_d;
			movement_s2 <= movement_d;
			phase_s2    <= phase_d;
		end
	end

endmodule

`default_nettype wire
